// File: hdl/u2u8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u2u8_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       text_end;
    logic       error;
  } out_item_t;

  typedef enum logic [1:0] {
    LEN_ONE   = 2'd0,
    LEN_TWO   = 2'd1,
    LEN_THREE = 2'd2,
    LEN_FOUR  = 2'd3
  } len_e;

  typedef struct packed {
    logic [20:0] code_point;
    len_e        len;
    logic        eot;
    logic        err;
  } job_t;

  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input len_e len,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      LEN_ONE: b = {1'b0, cp[6:0]};
      LEN_TWO: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LEN_THREE: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LEN_FOUR: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/u2u8_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u2u8_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire u2u8_pkg::in_item_t in_data_i,
  output logic                   push_o,
  output u2u8_pkg::job_t         job_o,
  input  wire logic              full_i
);

  logic       pending_q, pending_d;
  logic [9:0] high_q, high_d;
  logic       failed_q, failed_d;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       eot;
  logic [15:0] cu;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign cu         = in_data_i.code_unit;
  assign eot        = in_data_i.end_of_text;
  assign is_high    = (cu[15:10] == 6'b110110);
  assign is_low     = (cu[15:10] == 6'b110111);

  always_comb begin
    pending_d        = pending_q;
    high_d           = high_q;
    failed_d         = failed_q;
    push_o           = 1'b0;
    job_o.code_point = {5'd0, cu};
    job_o.len        = u2u8_pkg::LEN_ONE;
    job_o.eot        = eot;
    job_o.err        = 1'b0;
    if (accept) begin
      if (failed_q || (pending_q && !is_low) || (!pending_q && is_low)) begin
        push_o    = eot;
        job_o.err = 1'b1;
        failed_d  = 1'b1;
        pending_d = 1'b0;
        high_d    = 10'd0;
      end else if (pending_q) begin
        push_o           = 1'b1;
        job_o.code_point = 21'h10000 + {1'b0, high_q, cu[9:0]};
        job_o.len        = u2u8_pkg::LEN_FOUR;
        pending_d        = 1'b0;
        high_d           = 10'd0;
      end else if (is_high) begin
        if (eot) begin
          push_o    = 1'b1;
          job_o.err = 1'b1;
        end else begin
          pending_d = 1'b1;
          high_d    = cu[9:0];
        end
      end else begin
        push_o = 1'b1;
        if (cu < 16'h0080) begin
          job_o.len = u2u8_pkg::LEN_ONE;
        end else if (cu < 16'h0800) begin
          job_o.len = u2u8_pkg::LEN_TWO;
        end else begin
          job_o.len = u2u8_pkg::LEN_THREE;
        end
      end
      if (eot) begin
        pending_d = 1'b0;
        high_d    = 10'd0;
        failed_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      high_q    <= 10'd0;
      failed_q  <= 1'b0;
    end else begin
      pending_q <= pending_d;
      high_q    <= high_d;
      failed_q  <= failed_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/u2u8_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u2u8_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire u2u8_pkg::job_t job_i,
  output logic                full_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output u2u8_pkg::job_t      head_o
);

  localparam int unsigned PtrW = $clog2(u2u8_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(u2u8_pkg::QueueDepth + 1);

  u2u8_pkg::job_t slot_q [u2u8_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(u2u8_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(u2u8_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(u2u8_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/u2u8_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u2u8_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire u2u8_pkg::job_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output u2u8_pkg::out_item_t out_data_o
);

  logic                valid_q;
  u2u8_pkg::out_item_t data_q, data_d;
  logic [1:0]          idx_q;
  logic                load;
  logic                take;
  logic                last;

  assign load  = !valid_q || !out_stall_i;
  assign take  = load && !empty_i;
  assign last  = (idx_q == 2'(head_i.len));
  assign pop_o = take && last;

  always_comb begin
    data_d.out_byte    = head_i.err ? 8'h00
                                    : u2u8_pkg::enc_byte(head_i.code_point, head_i.len, idx_q);
    data_d.last_of_run = last;
    data_d.text_end    = last && head_i.eot;
    data_d.error       = head_i.err;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
      end
      if (take) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: hdl/utf16_to_utf8_transcoder.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  in_data_i (code_unit, end_of_text)
// out      output     out_valid_o / out_stall_i out_data_o (out_byte, last_of_run,
//                                              text_end, error)
//
// The front accepts one code unit per cycle while its two-entry job queue has room.
// The back gives one UTF-8 byte per cycle while the output is not stalled, and a unit
// gives one to four bytes; the output byte stream sets the sustained rate.
// A held high surrogate or a non-final unit of a failed text gives no output transaction.
// Reset clears the surrogate state, the queue and the output valid flag at once.
// A stall on the output backs up into the queue and then stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_transcoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire u2u8_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output u2u8_pkg::out_item_t      out_data_o
);

  logic           push;
  logic           full;
  logic           empty;
  logic           pop;
  u2u8_pkg::job_t job;
  u2u8_pkg::job_t head;

  u2u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (job),
    .full_i     (full)
  );

  u2u8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: hdl/u2u8_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u2u8_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire u2u8_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire u2u8_pkg::out_item_t out_data_o
);

  // A stalled input transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input transaction changed");

  // A stalled output transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // An error result carries no byte and closes both the run and the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |->
      out_data_o.out_byte == 8'h00 && out_data_o.last_of_run && out_data_o.text_end)
    else $error("malformed error result");

  // The text end is always the final result of its unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.text_end |-> out_data_o.last_of_run)
    else $error("text end without end of run");

  // The input only stalls while results are backed up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with nothing at the output");

endmodule

bind utf16_to_utf8_transcoder u2u8_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: verif/utf8_stream_checker.sv
`timescale 1ns / 1ps

module utf8_stream_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  u2u8_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  u2u8_pkg::out_item_t out_data_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         bytes_due_o
);

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;

  u2u8_pkg::out_item_t utf8_due_q[$];
  logic                pending_high;
  logic [9:0]          high_bits;
  logic                text_failed;
  int unsigned         mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_text();
    pending_high = 1'b0;
    high_bits    = '0;
    text_failed  = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last, input logic tend,
                           input logic err);
    u2u8_pkg::out_item_t item;
    item.out_byte    = b;
    item.last_of_run = last;
    item.text_end    = tend;
    item.error       = err;
    utf8_due_q.insert(utf8_due_q.size(), item);
  endtask

  task automatic break_text(input logic eot);
    if (eot) begin
      push_byte(8'h00, 1'b1, 1'b1, 1'b1);
      clear_text();
    end else begin
      text_failed  = 1'b1;
      pending_high = 1'b0;
      high_bits    = '0;
    end
  endtask

  task automatic transcode_unit(input u2u8_pkg::in_item_t it);
    logic [15:0] u;
    logic        eot;
    logic        is_high;
    logic        is_low;
    logic [20:0] cp;
    logic [7:0]  seq [4];
    int          n;
    u       = it.code_unit;
    eot     = it.end_of_text;
    is_high = (u >= HighFirst) && (u <= HighLast);
    is_low  = (u >= LowFirst) && (u <= LowLast);
    if (text_failed || (pending_high && !is_low) || (!pending_high && is_low) ||
        (!pending_high && is_high && eot)) begin
      break_text(eot);
      return;
    end
    if (pending_high) begin
      cp           = 21'h10000 + {1'b0, high_bits, u[9:0]};
      pending_high = 1'b0;
      high_bits    = '0;
    end else if (is_high) begin
      pending_high = 1'b1;
      high_bits    = u[9:0];
      return;
    end else begin
      cp = {5'b0, u};
    end
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      seq[0] = 8'hC0 | 8'(cp >> 6);
      seq[1] = 8'h80 | 8'(cp & 21'h3F);
      n = 2;
    end else if (cp < 21'h10000) begin
      seq[0] = 8'hE0 | 8'(cp >> 12);
      seq[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
      seq[2] = 8'h80 | 8'(cp & 21'h3F);
      n = 3;
    end else begin
      seq[0] = 8'hF0 | 8'(cp >> 18);
      seq[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
      seq[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
      seq[3] = 8'h80 | 8'(cp & 21'h3F);
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      push_byte(seq[k], k == n - 1, (k == n - 1) && eot, 1'b0);
    end
    if (eot) begin
      clear_text();
    end
  endtask

  task automatic check_result(input u2u8_pkg::out_item_t got);
    u2u8_pkg::out_item_t want;
    if (utf8_due_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction: byte %h", got.out_byte));
      return;
    end
    want = utf8_due_q.pop_front();
    if (got.out_byte !== want.out_byte) begin
      report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
    end
    if (got.last_of_run !== want.last_of_run) begin
      report_mismatch($sformatf("last_of_run %b, expected %b (byte %h)",
                                got.last_of_run, want.last_of_run, want.out_byte));
    end
    if (got.text_end !== want.text_end) begin
      report_mismatch($sformatf("text_end %b, expected %b (byte %h)",
                                got.text_end, want.text_end, want.out_byte));
    end
    if (got.error !== want.error) begin
      report_mismatch($sformatf("error %b, expected %b (byte %h)",
                                got.error, want.error, want.out_byte));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text();
      utf8_due_q.delete();
      mismatches       = 0;
      mismatch_count_o <= 0;
      bytes_due_o      <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        transcode_unit(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
      mismatch_count_o <= mismatches;
      bytes_due_o      <= utf8_due_q.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  u2u8_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  u2u8_pkg::out_item_t out_data_o;
  int unsigned         mismatch_count;
  int unsigned         bytes_due;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned units_sent    = 0;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  utf16_to_utf8_transcoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  utf8_stream_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .bytes_due_o      (bytes_due)
  );

  // A long hold-off lets the input side back up until the block stalls it.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = 50;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_unit(input logic [15:0] cu, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {cu, eot};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    units_sent++;
  endtask

  task automatic send_random_text();
    int          n;
    int          kind;
    logic        broken;
    logic        last;
    logic [15:0] v;
    n      = $urandom_range(1, 6);
    broken = ($urandom_range(99) < 20);
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1);
      kind = $urandom_range(0, broken ? 11 : 8);
      case (kind)
        0, 1, 2: send_unit(16'($urandom_range(0, 16'h007F)), last);
        3, 4: send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
        5, 6: begin
          do v = 16'($urandom_range(16'h0800, 16'hFFFF));
          while (v >= 16'hD800 && v <= 16'hDFFF);
          send_unit(v, last);
        end
        7, 8: begin
          send_unit(16'hD800 + 16'($urandom_range(0, 1023)), 1'b0);
          send_unit(16'hDC00 + 16'($urandom_range(0, 1023)), last);
        end
        9: begin
          v = 16'($urandom());
          send_unit(v, last);
        end
        10: send_unit(16'hDC00 + 16'($urandom_range(0, 1023)), last);
        default: send_unit(16'hD800 + 16'($urandom_range(0, 1023)), last);
      endcase
    end
  endtask

  initial begin
    int unsigned base;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 60;
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // High surrogate followed by an ordinary character, which fails the rest of the text.
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h00E9, 1'b0);
    send_unit(16'h0042, 1'b1);
    // Lone low surrogate, ending on a high surrogate.
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hD800, 1'b1);
    // High surrogate at the end of the text.
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b1);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'h0041, 1'b1);

    base = units_sent;
    while (units_sent < base + 67) send_random_text();
    send_idle_pct = 60;
    recv_idle_pct = 21;
    while (units_sent < base + 134) send_random_text();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    while (units_sent < base + 200) send_random_text();
    in_valid_i <= 1'b0;

    while (bytes_due != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS utf16_to_utf8_transcoder");
    end else begin
      $display("FAIL utf16_to_utf8_transcoder");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL utf16_to_utf8_transcoder");
    $finish;
  end

endmodule

// File: files.f
hdl/u2u8_pkg.sv
hdl/u2u8_front.sv
hdl/u2u8_queue.sv
hdl/u2u8_back.sv
hdl/utf16_to_utf8_transcoder.sv
hdl/u2u8_checker.sv
verif/utf8_stream_checker.sv
verif/tb.sv
